FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the affine point transform block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define APT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define APT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/apt2d_pkg.sv
// ---------------------------------------------------------------------------
// apt2d_pkg
// Types, constants and tables shared by the 2D affine point transform.
// ---------------------------------------------------------------------------
package apt2d_pkg;

    // Default build settings
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // Step index field width (covers up to 24 CORDIC steps)
    localparam int STEP_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_ANGLE    = 3'd2,
        CFG_SCALE_X  = 3'd3,
        CFG_SCALE_Y  = 3'd4
    } t_cfg_idx;

    // Matrix entry indexes: world = [a c; b d] * local
    localparam logic [1:0] ENT_A = 2'd0;
    localparam logic [1:0] ENT_B = 2'd1;
    localparam logic [1:0] ENT_C = 2'd2;
    localparam logic [1:0] ENT_D = 2'd3;

    // Fixed-point constants
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] ENTRY_ONE       = 32'd65536;
    localparam logic [31:0] INT32_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN       = 32'h8000_0000;

    // Request payloads
    typedef struct packed {
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic               saturated;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_TRIG,
        S_ENTRY,
        S_MUL0,
        S_MUL1,
        S_SUM,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic              cap_in;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step;
        logic              trig_load;
        logic              entry_load;
        logic [1:0]        ent;
        logic              mul0;
        logic              mul1;
        logic              sum;
        logic              load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic cfg_hit;
    } t_stat;

    // CORDIC arctangent table, units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10680862;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670675;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/apt2d_ctrl.sv
// ---------------------------------------------------------------------------
// apt2d_ctrl
// Sequencer for the point transform: matrix rebuild on stale, then the
// multiply, sum and clamp steps; owns the result valid flag.
// ---------------------------------------------------------------------------
module apt2d_ctrl #(
    parameter int CORDIC_STEPS = apt2d_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  apt2d_pkg::t_stat  i_stat,
    output apt2d_pkg::t_cmd   o_cmd
);
    import apt2d_pkg::*;

    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    t_state        r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic [1:0]    r_ent, n_ent;
    logic          r_stale, n_stale;
    logic          r_out_valid, n_out_valid;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_ent       <= ENT_A;
            r_stale     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_ent       <= n_ent;
            r_stale     <= n_stale;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_ent       = r_ent;
        n_stale     = r_stale;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_ready     = 1'b0;

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap_in = 1'b1;
                    if (r_stale) begin
                        o_cmd.cordic_init = 1'b1;
                        n_step            = '0;
                        n_state           = S_CORDIC;
                    end else begin
                        n_state = S_MUL0;
                    end
                end
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.step        = STEP_W'(r_step);
                if (r_step == SW'(CORDIC_STEPS - 1)) begin
                    n_state = S_TRIG;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_TRIG: begin
                o_cmd.trig_load = 1'b1;
                n_ent           = ENT_A;
                n_state         = S_ENTRY;
            end
            S_ENTRY: begin
                o_cmd.entry_load = 1'b1;
                o_cmd.ent        = r_ent;
                if (r_ent == ENT_D) begin
                    n_stale = 1'b0;
                    n_state = S_MUL0;
                end else begin
                    n_ent = r_ent + 1'b1;
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // load only into an empty or draining output register
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // any register write marks the matrix stale
        if (i_stat.cfg_hit) begin
            n_stale = 1'b1;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: sv/apt2d_dp.sv
// ---------------------------------------------------------------------------
// apt2d_dp
// Datapath: configuration registers, iterative CORDIC, matrix entry build,
// point multiply, offset add and saturation.
// ---------------------------------------------------------------------------
module apt2d_dp #(
    parameter int FRAC_BITS = apt2d_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [apt2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [apt2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  apt2d_pkg::t_in                    i_data,
    input  apt2d_pkg::t_cmd                   i_cmd,
    output apt2d_pkg::t_stat                  o_stat,
    output apt2d_pkg::t_out                   o_data
);
    import apt2d_pkg::*;

    localparam int CW = 34;              // CORDIC x/y, Q30
    localparam int TS = 30 - FRAC_BITS;  // trig rounding shift
    localparam int TW = FRAC_BITS + 2;   // rounded trig width
    localparam int PW = TW + 17;         // scale * trig product
    localparam int ES = FRAC_BITS - 8;   // entry rounding shift
    localparam int EW = PW - ES;         // entry width before extension

    localparam logic signed [CW-1:0] TRND = CW'(1) << (TS - 1);
    localparam logic signed [PW-1:0] ERND =
        (ES > 0) ? (PW'(1) << ((ES > 0) ? ES - 1 : 0)) : '0;
    localparam logic [66:0] RND16 = 67'h8000;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } t_quad;

    // Configuration registers
    logic signed [31:0] r_off_x, r_off_y;
    logic [15:0]        r_angle;
    logic signed [15:0] r_scale_x, r_scale_y;

    // CORDIC and trig
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [31:0]   r_cz;
    t_quad                r_quad;
    logic signed [TW-1:0] r_cos, r_sin;

    // Matrix and point path
    logic signed [31:0] r_m [4];
    logic signed [31:0] r_lx, r_ly;
    logic signed [63:0] r_pa, r_pb, r_pc, r_pd;
    logic [66:0]        r_tx, r_ty;
    t_out               r_out;

    // Combinational
    logic signed [CW-1:0] w_dx, w_dy;
    logic signed [31:0]   w_atan;
    logic signed [CW-1:0] w_cr, w_sr, w_csh, w_ssh;
    logic signed [TW-1:0] w_c, w_s, w_cos, w_sin;
    logic signed [16:0]   w_esc;
    logic signed [TW-1:0] w_etr;
    logic signed [PW-1:0] w_eprod, w_eround, w_esh;
    logic signed [31:0]   w_entry;
    logic                 w_ovx, w_ovy;
    logic [31:0]          w_wx, w_wy;

    assign o_stat.cfg_hit = i_cfg_valid && (i_cfg_index <= CFG_SCALE_Y);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_angle   <= '0;
            r_scale_x <= 16'sd256;
            r_scale_y <= 16'sd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET_X: r_off_x   <= i_cfg_data;
                CFG_OFFSET_Y: r_off_y   <= i_cfg_data;
                CFG_ANGLE:    r_angle   <= i_cfg_data[15:0];
                CFG_SCALE_X:  r_scale_x <= i_cfg_data[15:0];
                CFG_SCALE_Y:  r_scale_y <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // One CORDIC micro-rotation per cycle
    assign w_dx   = r_cy >>> i_cmd.step;
    assign w_dy   = r_cx >>> i_cmd.step;
    assign w_atan = {2'b00, atan_turn(i_cmd.step)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            // residual in [-8192, 8191] is the low 14 angle bits, signed
            r_cx   <= CW'(CORDIC_GAIN_Q30);
            r_cy   <= '0;
            r_cz   <= {{2{r_angle[13]}}, r_angle[13:0], 16'h0000};
            r_quad <= t_quad'(r_angle[15:14] + {1'b0, r_angle[13]});
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[31]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end
        end
    end

    // Round to FRAC_BITS, then fold the quadrant back in
    assign w_cr  = r_cx + TRND;
    assign w_sr  = r_cy + TRND;
    assign w_csh = w_cr >>> TS;
    assign w_ssh = w_sr >>> TS;
    assign w_c   = w_csh[TW-1:0];
    assign w_s   = w_ssh[TW-1:0];

    always_comb begin
        case (r_quad)
            QUAD_0:   begin w_cos = w_c;  w_sin = w_s;  end
            QUAD_90:  begin w_cos = -w_s; w_sin = w_c;  end
            QUAD_180: begin w_cos = -w_c; w_sin = -w_s; end
            QUAD_270: begin w_cos = w_s;  w_sin = -w_c; end
            default:  begin w_cos = w_c;  w_sin = w_s;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig_load) begin
            r_cos <= w_cos;
            r_sin <= w_sin;
        end
    end

    // Matrix entry: Q8.8 scale times trig, rounded to Q16.16
    always_comb begin
        case (i_cmd.ent)
            ENT_A:   begin w_esc = {r_scale_x[15], r_scale_x};    w_etr = r_cos; end
            ENT_B:   begin w_esc = {r_scale_x[15], r_scale_x};    w_etr = r_sin; end
            ENT_C:   begin w_esc = -{r_scale_y[15], r_scale_y};   w_etr = r_sin; end
            ENT_D:   begin w_esc = {r_scale_y[15], r_scale_y};    w_etr = r_cos; end
            default: begin w_esc = {r_scale_x[15], r_scale_x};    w_etr = r_cos; end
        endcase
    end

    assign w_eprod  = w_esc * w_etr;
    assign w_eround = w_eprod + ERND;
    assign w_esh    = w_eround >>> ES;
    assign w_entry  = {{(32-EW){w_esh[EW-1]}}, w_esh[EW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[ENT_A] <= ENTRY_ONE;
            r_m[ENT_B] <= '0;
            r_m[ENT_C] <= '0;
            r_m[ENT_D] <= ENTRY_ONE;
        end else if (i_cmd.entry_load) begin
            r_m[i_cmd.ent] <= w_entry;
        end
    end

    // Point capture, two multiply steps, then offset and rounding add
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_lx <= i_data.local_x;
            r_ly <= i_data.local_y;
        end
        if (i_cmd.mul0) begin
            r_pa <= r_m[ENT_A] * r_lx;
            r_pb <= r_m[ENT_B] * r_lx;
        end
        if (i_cmd.mul1) begin
            r_pc <= r_m[ENT_C] * r_ly;
            r_pd <= r_m[ENT_D] * r_ly;
        end
        if (i_cmd.sum) begin
            r_tx <= {{3{r_pa[63]}}, r_pa} + {{3{r_pc[63]}}, r_pc}
                  + {{19{r_off_x[31]}}, r_off_x, 16'h0000} + RND16;
            r_ty <= {{3{r_pb[63]}}, r_pb} + {{3{r_pd[63]}}, r_pd}
                  + {{19{r_off_y[31]}}, r_off_y, 16'h0000} + RND16;
        end
    end

    // Saturate: fits 32 bits only if bits 66..47 all match
    assign w_ovx = !((&r_tx[66:47]) || !(|r_tx[66:47]));
    assign w_ovy = !((&r_ty[66:47]) || !(|r_ty[66:47]));
    assign w_wx  = w_ovx ? (r_tx[66] ? INT32_MIN : INT32_MAX) : r_tx[47:16];
    assign w_wy  = w_ovy ? (r_ty[66] ? INT32_MIN : INT32_MAX) : r_ty[47:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.world_x   <= w_wx;
            r_out.world_y   <= w_wy;
            r_out.saturated <= w_ovx || w_ovy;
        end
    end

    assign o_data = r_out;

endmodule

FILE: sv/affine_point_transform_2d_core.sv
// ---------------------------------------------------------------------------
// affine_point_transform_2d_core
// Scale, rotate and translate of Q16.16 points with a cached 2x2 matrix.
// ---------------------------------------------------------------------------
// While the matrix is current, a point goes from acceptance to the next
// acceptance through capture, the paired 32x32 multiplies of S_MUL0 and S_MUL1,
// the rounding and offset add, and the clamp into the output register. The
// first point after a register write rebuilds the matrix first: one CORDIC
// micro-rotation per cycle, then rounding and folding of the quadrant, and the
// four entries built in turn on the single entry multiplier.
// The output register lets a new point be accepted while a result waits.
// Register writes are always ready and must be made while the block is idle.
`include "assert_macros.svh"

module affine_point_transform_2d_core #(
    parameter int CORDIC_STEPS = apt2d_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = apt2d_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  apt2d_pkg::t_in                    i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output apt2d_pkg::t_out                   o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [apt2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [apt2d_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import apt2d_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    apt2d_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    apt2d_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_data      (o_data)
    );

    // Assertions
    `APT_ASSERT(a_no_overwrite, i_clk, i_rst_n, (cmd.load_out |-> (!o_valid || i_ready)), "result overwritten while waiting")
    `APT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, ((i_valid && o_ready) |=> !o_ready), "request accepted while busy")
    `APT_ASSERT(a_rebuild_after_cfg, i_clk, i_rst_n, ((i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_SCALE_Y)) ##1 (i_valid && o_ready) |-> cmd.cordic_init), "matrix not rebuilt after write")
    `APT_ASSERT_ALWAYS(a_one_step, i_clk, $onehot0({cmd.cap_in, cmd.cordic_step, cmd.trig_load, cmd.entry_load, cmd.mul0, cmd.mul1, cmd.sum, cmd.load_out}), "overlapping datapath commands")

endmodule

FILE: bench/apt2d_point_checker.sv
// ---------------------------------------------------------------------------
// apt2d_point_checker
// Watches the point, result and register channels of the affine transform,
// predicts each world point and compares it with what the block returns.
// ---------------------------------------------------------------------------
module apt2d_point_checker #(
    parameter int CORDIC_STEPS = apt2d_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = apt2d_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pt_valid,
    input  logic                             i_pt_ready,
    input  apt2d_pkg::t_in                   i_pt,
    input  logic                             i_world_valid,
    input  logic                             i_world_ready,
    input  apt2d_pkg::t_out                  i_world,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [apt2d_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apt2d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_pending,
    output int                               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import apt2d_pkg::*;

    // Inverse CORDIC gain in Q30 and arctangent steps in 2^-32 turn
    localparam longint GAIN_INV_Q30 = 652032874;
    localparam longint ARCTAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670675, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint Q16_MAX = 64'sd2147483647;
    localparam longint Q16_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        QUAD_EAST,
        QUAD_NORTH,
        QUAD_WEST,
        QUAD_SOUTH
    } t_quadrant;

    // Shadow of the transform registers and of the cached matrix
    logic signed [31:0] offset_x_q;
    logic signed [31:0] offset_y_q;
    logic        [15:0] angle_q;
    logic signed [15:0] scale_x_q;
    logic signed [15:0] scale_y_q;
    logic signed [31:0] mat_a;
    logic signed [31:0] mat_b;
    logic signed [31:0] mat_c;
    logic signed [31:0] mat_d;
    bit                 matrix_stale;

    t_out world_due [$];
    t_out due_pt;
    int   fails;

    // Arithmetic right shift with round half up
    function automatic longint round_half_up(input longint v, input int s);
        if (s == 0) return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Rotation-mode CORDIC on the residual, quadrant folded in exactly
    function automatic void cordic_cos_sin(input logic [15:0] turn,
                                           output longint cos_v,
                                           output longint sin_v);
        logic [15:0] biased;
        t_quadrant   quad;
        longint      x, y, z, dx, dy, c, s;
        int          i;
        biased = turn + 16'd8192;
        quad   = t_quadrant'(biased[15:14]);
        z      = (longint'(biased[13:0]) - 8192) * 65536;
        x      = GAIN_INV_Q30;
        y      = 0;
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
        end
        c = round_half_up(x, 30 - FRAC_BITS);
        s = round_half_up(y, 30 - FRAC_BITS);
        case (quad)
            QUAD_EAST: begin
                cos_v = c;
                sin_v = s;
            end
            QUAD_NORTH: begin
                cos_v = -s;
                sin_v = c;
            end
            QUAD_WEST: begin
                cos_v = -c;
                sin_v = -s;
            end
            default: begin
                cos_v = s;
                sin_v = -c;
            end
        endcase
    endfunction

    // Clamp to signed 32 bits, flagging any clamp
    function automatic logic signed [31:0] clamp_q16(input longint v, inout bit sat);
        if (v > Q16_MAX) begin
            sat = 1'b1;
            return Q16_MAX[31:0];
        end
        if (v < Q16_MIN) begin
            sat = 1'b1;
            return Q16_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // World position of one point; rebuilds the matrix if a write made it stale
    function automatic t_out predict_world(input t_in pt);
        longint cs, sn, sx, sy, lx, ly, wx, wy;
        bit     sat;
        t_out   w;
        if (matrix_stale) begin
            cordic_cos_sin(angle_q, cs, sn);
            sx    = longint'(scale_x_q);
            sy    = longint'(scale_y_q);
            mat_a = 32'(round_half_up(sx * cs, FRAC_BITS - 8));
            mat_b = 32'(round_half_up(sx * sn, FRAC_BITS - 8));
            mat_c = 32'(round_half_up(-sy * sn, FRAC_BITS - 8));
            mat_d = 32'(round_half_up(sy * cs, FRAC_BITS - 8));
            matrix_stale = 1'b0;
        end
        lx  = longint'(pt.local_x);
        ly  = longint'(pt.local_y);
        wx  = round_half_up(longint'(mat_a) * lx + longint'(mat_c) * ly, 16)
              + longint'(offset_x_q);
        wy  = round_half_up(longint'(mat_b) * lx + longint'(mat_d) * ly, 16)
              + longint'(offset_y_q);
        sat = 1'b0;
        w.world_x   = clamp_q16(wx, sat);
        w.world_y   = clamp_q16(wy, sat);
        w.saturated = sat;
        return w;
    endfunction

    // Track registers, queue predictions, check returned points
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offset_x_q   = '0;
            offset_y_q   = '0;
            angle_q      = '0;
            scale_x_q    = 16'sd256;
            scale_y_q    = 16'sd256;
            mat_a        = ENTRY_ONE;
            mat_b        = '0;
            mat_c        = '0;
            mat_d        = ENTRY_ONE;
            matrix_stale = 1'b1;
            fails        = 0;
            world_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                // unknown indexes leave the matrix alone
                case (i_cfg_index)
                    CFG_OFFSET_X: begin
                        offset_x_q   = i_cfg_data;
                        matrix_stale = 1'b1;
                    end
                    CFG_OFFSET_Y: begin
                        offset_y_q   = i_cfg_data;
                        matrix_stale = 1'b1;
                    end
                    CFG_ANGLE: begin
                        angle_q      = i_cfg_data[15:0];
                        matrix_stale = 1'b1;
                    end
                    CFG_SCALE_X: begin
                        scale_x_q    = i_cfg_data[15:0];
                        matrix_stale = 1'b1;
                    end
                    CFG_SCALE_Y: begin
                        scale_y_q    = i_cfg_data[15:0];
                        matrix_stale = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_pt_valid && i_pt_ready) world_due.push_back(predict_world(i_pt));
            if (i_world_valid && i_world_ready) begin
                if (world_due.size() == 0) begin
                    $error("unexpected world point x=%0d y=%0d sat=%0b",
                           i_world.world_x, i_world.world_y, i_world.saturated);
                    fails++;
                end else begin
                    due_pt = world_due.pop_front();
                    if (due_pt.world_x !== i_world.world_x) begin
                        $error("world_x mismatch: expected %0d, actual %0d",
                               due_pt.world_x, i_world.world_x);
                        fails++;
                    end
                    if (due_pt.world_y !== i_world.world_y) begin
                        $error("world_y mismatch: expected %0d, actual %0d",
                               due_pt.world_y, i_world.world_y);
                        fails++;
                    end
                    if (due_pt.saturated !== i_world.saturated) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               due_pt.saturated, i_world.saturated);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= world_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives points and transform settings into the affine point transform core
// under several idle and stall patterns; the checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import apt2d_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_POINTS  = 235;
    localparam int PAUSE_ODDS    = 60;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_FIRST = CFG_IDX_W'(CFG_SCALE_Y + 1);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LAST  = '1;

    localparam logic signed [31:0] LIMIT_COORDS [7] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1, 32'sd65536, -32'sd65536
    };
    localparam logic [15:0] KEY_ANGLES [10] = '{
        16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd24575,
        16'd24576, 16'd32768, 16'd49152, 16'd57343, 16'd65535
    };
    localparam logic signed [15:0] KEY_SCALES [6] = '{
        -16'sd32768, 16'sd32767, 16'sd256, -16'sd256, 16'sd0, 16'sd1
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    t_in                   i_data      = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int pending;
    int fail_count;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    int phase;
    int n;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    affine_point_transform_2d_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    apt2d_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pt_valid    (i_valid),
        .i_pt_ready    (o_ready),
        .i_pt          (i_data),
        .i_world_valid (o_valid),
        .i_world_ready (i_ready),
        .i_world       (o_data),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: cycles in which no request of any channel completes
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("affine_point_transform_2d_core test failed");
        $finish;
    end

    // Coordinate mix: limits, small values, scaled-down and full range
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0, 1:    return LIMIT_COORDS[$urandom_range(6)];
            2, 3, 4: return int'($urandom_range(2097152)) - 1048576;
            5, 6:    return $signed($urandom) >>> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_point();
        t_in pt;
        pt.local_x = rand_coord();
        pt.local_y = rand_coord();
        return pt;
    endfunction

    function automatic logic signed [15:0] rand_scale();
        case ($urandom_range(3))
            0:       return KEY_SCALES[$urandom_range(5)];
            1:       return 16'(int'($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // One point request; valid stays up across back-to-back requests
    task automatic send_point(input t_in pt);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= pt;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Hold off new points until every result is back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Program the whole transform; noisy adds junk upper bits, a repeated
    // write and a write to an unused index
    task automatic apply_transform(input logic [31:0] ox, input logic [31:0] oy,
                                   input logic [15:0] ang, input logic [15:0] sx,
                                   input logic [15:0] sy, input bit noisy);
        logic [15:0] junk;
        wait_for_results();
        junk = noisy ? 16'($urandom) : 16'h0;
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_ANGLE, {junk, ang});
        write_reg(CFG_SCALE_X, {~junk, sx});
        write_reg(CFG_SCALE_Y, {junk, sy});
        if (noisy) begin
            write_reg(CFG_OFFSET_X, ox);
            write_reg(3'($urandom_range(IDX_SPARE_LAST, IDX_SPARE_FIRST)), $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: limit coordinates through the identity matrix
        for (n = 0; n < 7; n++) send_point(t_in'{LIMIT_COORDS[n], LIMIT_COORDS[6 - n]});

        // Directed: largest scales, quarter turn, extreme offsets; overflows
        apply_transform(32'h7FFF_FFFF, 32'h8000_0000, 16'd16384, 16'h7FFF, 16'h8000, 1'b1);
        for (n = 0; n < 7; n++) send_point(t_in'{LIMIT_COORDS[n], LIMIT_COORDS[n]});

        // Directed: residual boundary and the last quadrant
        apply_transform(32'h0, 32'h0, 16'd8192, 16'sd256, -16'sd256, 1'b0);
        for (n = 0; n < 3; n++) send_point(rand_point());
        apply_transform(32'h0001_0000, 32'hFFFF_0000, 16'd49152, 16'sd384, 16'sd128, 1'b1);
        for (n = 0; n < 3; n++) send_point(rand_point());

        // Random phases, each with its own setting and idle pattern
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
                                   16'h7FFF, 16'h7FFF, 1'b1);
                1: apply_transform(32'h8000_0000, 32'h8000_0000, 16'h0000,
                                   16'h8000, 16'h8000, 1'b1);
                2: apply_transform(32'h0, 32'h0, 16'd32768, 16'sd256, 16'sd256, 1'b0);
                default: apply_transform($urandom, $urandom,
                                         ($urandom_range(1) == 0) ? KEY_ANGLES[$urandom_range(9)]
                                                                 : 16'($urandom),
                                         rand_scale(), rand_scale(),
                                         1'($urandom_range(1)));
            endcase
            case (phase % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 82;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 82;
                end
                default: begin
                    tx_idle_pct  = 24;
                    rx_stall_pct = 24;
                end
            endcase
            for (n = 0; n < PHASE_POINTS; n++) begin
                if ($urandom_range(PAUSE_ODDS - 1) == 0) wait_for_results();
                send_point(rand_point());
            end
        end

        // Drain and verdict
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("affine_point_transform_2d_core test passed");
        end else begin
            $display("affine_point_transform_2d_core test failed");
        end
        $finish;
    end

endmodule
